// ===== hdl/pcp_pkg.sv =====
// shared types, constants and a saturation helper for the perceptron unit
// no dependencies

package pcp_pkg;

  localparam int unsigned FEAT_W = 8;
  localparam int unsigned WGT_W  = 24;
  localparam int unsigned LR_W   = 8;
  localparam int unsigned SUM_W  = 40;
  localparam int unsigned ACT_W  = 32;
  localparam int unsigned PROD_W = FEAT_W + WGT_W;

  localparam logic [LR_W-1:0] LR_RESET = 8'd26;

  // what enters the tail of the cell ring on a rotation
  typedef enum logic [1:0] {
    FEED_LOAD,
    FEED_PASS,
    FEED_UPDATE
  } feed_mode_t;

  typedef struct packed {
    logic shift;
    logic clr;
  } cell_ctrl_t;

  // saturate a widened weight or bias sum to the 24-bit range
  function automatic logic signed [WGT_W-1:0] sat_w(input logic signed [WGT_W+1:0] v);
    logic signed [WGT_W+1:0] hi;
    logic signed [WGT_W+1:0] lo;
    hi = (WGT_W+2)'(signed'(25'sh7FFFFF));
    lo = -(WGT_W+2)'(signed'(25'sh800000));
    if (v > hi) begin
      return {1'b0, {(WGT_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(WGT_W-1){1'b0}}};
    end else begin
      return v[WGT_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/pcp_cell.sv =====
// one cell of the weight ring: a weight and the stored feature of its position
// depends on pcp_pkg

module pcp_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pcp_pkg::cell_ctrl_t               ctrl,
  input  logic signed [pcp_pkg::WGT_W-1:0]  w_in,
  input  logic signed [pcp_pkg::FEAT_W-1:0] f_in,
  output logic signed [pcp_pkg::WGT_W-1:0]  w_q,
  output logic signed [pcp_pkg::FEAT_W-1:0] f_q
);

  logic signed [pcp_pkg::WGT_W-1:0]  w_r;
  logic signed [pcp_pkg::FEAT_W-1:0] f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= '0;
      f_r <= '0;
    end else if (ctrl.shift) begin
      w_r <= w_in;
      f_r <= f_in;
    end else if (ctrl.clr) begin
      f_r <= '0;
    end
  end

  assign w_q = w_r;
  assign f_q = f_r;

endmodule

// ===== hdl/pcp_upd.sv =====
// tail feed of the cell ring: loads a new feature, passes the head on, or
// applies the learning rule to the head weight; depends on pcp_pkg

module pcp_upd (
  input  pcp_pkg::feed_mode_t               mode,
  input  logic signed [pcp_pkg::FEAT_W-1:0] new_f,
  input  logic signed [pcp_pkg::WGT_W-1:0]  head_w,
  input  logic signed [pcp_pkg::FEAT_W-1:0] head_f,
  input  logic        [pcp_pkg::LR_W-1:0]   lr,
  input  logic                              err_neg,
  output logic signed [pcp_pkg::WGT_W-1:0]  tail_w,
  output logic signed [pcp_pkg::FEAT_W-1:0] tail_f
);

  localparam int unsigned MW = pcp_pkg::LR_W + pcp_pkg::FEAT_W + 1;

  logic signed [MW-1:0]                mul;
  logic signed [MW:0]                  delta;
  logic signed [pcp_pkg::WGT_W+1:0]    wsum;

  always_comb begin
    mul   = MW'(signed'({1'b0, lr})) * MW'(head_f);
    delta = err_neg ? -(MW+1)'(mul) : (MW+1)'(mul);
    wsum  = (pcp_pkg::WGT_W+2)'(head_w) + (pcp_pkg::WGT_W+2)'(delta);
    case (mode)
      pcp_pkg::FEED_LOAD: begin
        tail_w = head_w;
        tail_f = new_f;
      end
      pcp_pkg::FEED_PASS: begin
        tail_w = head_w;
        tail_f = head_f;
      end
      pcp_pkg::FEED_UPDATE: begin
        // feature is consumed by the update, so it leaves as zero
        tail_w = pcp_pkg::sat_w(wsum);
        tail_f = '0;
      end
      default: begin
        tail_w = head_w;
        tail_f = head_f;
      end
    endcase
  end

endmodule

// ===== hdl/perceptron_online_train_predict_unit.sv =====
// top level of the streaming perceptron: predict and online training
// depends on pcp_pkg, pcp_cell, pcp_upd
//
// input channel (in_valid / in_stall): one signed feature per transfer; in_is_last
//   marks the final feature of a sample, and in_opcode and in_target are taken
//   from that final transfer (opcode 1 = train towards target)
// result channel (out_valid / out_stall): one transfer per sample, out_prediction
//   (1 when the activation is zero or more) and out_activation (bias plus
//   weighted sum, Q.8, saturated to 32 bits)
// cfg channel (cfg_valid / cfg_ready): Q0.8 learning rate; always ready and
//   meant to be written only while the unit is idle
// timing: features are taken one per cycle while the unit is in ST_IDLE; the
//   last feature transfer is followed by ST_ADD and ST_EVAL, and out_valid
//   rises from ST_EVAL once the result register is free. the ring of
//   N_FEATURES cells then rotates back home and, on a training sample with a
//   wrong prediction, takes one more lap in which each weight passes the single
//   update multiplier at the head cell
// reset: synchronous active low; weights, bias and sample state go to zero and
//   the learning rate to 26 (about 0.1)
// stalls: a held result sits in the output register; new features are still
//   taken, and only the end of the next sample waits for the register to drain

module perceptron_online_train_predict_unit #(
  parameter int unsigned N_FEATURES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // feature stream
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [pcp_pkg::FEAT_W-1:0] in_feature,
  input  logic                              in_is_last,
  input  logic                              in_opcode,
  input  logic                              in_target,
  // results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_prediction,
  output logic signed [pcp_pkg::ACT_W-1:0]  out_activation,
  // learning rate register
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic        [pcp_pkg::LR_W-1:0]   cfg_data
);

  localparam int unsigned PW = $clog2(N_FEATURES + 1);
  localparam logic [PW-1:0] N_CNT = PW'(N_FEATURES);

  typedef enum logic [2:0] {
    ST_IDLE,   // streaming features
    ST_ADD,    // last product folds into the sum
    ST_EVAL,   // activation, result register, bias update
    ST_ALIGN,  // rotate the ring back to its home position
    ST_TRAIN   // one lap applying the learning rule
  } state_t;

  state_t state_r, state_nxt;

  logic        [pcp_pkg::LR_W-1:0]    lr_r;
  logic signed [pcp_pkg::WGT_W-1:0]   bias_r;
  logic signed [pcp_pkg::SUM_W-1:0]   sum_r;
  logic signed [pcp_pkg::PROD_W-1:0]  prod_r;
  logic                               prod_v_r;
  logic        [PW-1:0]               pos_r;
  logic        [PW-1:0]               cnt_r;
  logic                               op_r;
  logic                               tgt_r;
  logic                               train_r;
  logic                               err_neg_r;
  logic                               out_valid_r;
  logic                               out_pred_r;
  logic signed [pcp_pkg::ACT_W-1:0]   out_act_r;

  // ring of cells, head is cell 0, tail is the last cell
  logic signed [pcp_pkg::WGT_W-1:0]   w_q [N_FEATURES];
  logic signed [pcp_pkg::FEAT_W-1:0]  f_q [N_FEATURES];
  logic signed [pcp_pkg::WGT_W-1:0]   tail_w;
  logic signed [pcp_pkg::FEAT_W-1:0]  tail_f;
  pcp_pkg::cell_ctrl_t                cell_ctrl;
  pcp_pkg::feed_mode_t                feed_mode;

  logic                               in_xfer;
  logic                               store;
  logic                               eval_go;
  logic signed [pcp_pkg::SUM_W-1:0]   act_full;
  logic                               pred_now;
  logic                               train_now;
  logic signed [pcp_pkg::ACT_W-1:0]   act_sat;
  logic signed [pcp_pkg::LR_W+1:0]    step;
  logic signed [pcp_pkg::WGT_W+1:0]   bias_sum;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign store     = in_xfer && (pos_r < N_CNT);
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_prediction = out_pred_r;
  assign out_activation = out_act_r;

  // the result register must be free before a new result is written
  assign eval_go = (state_r == ST_EVAL) && !(out_valid_r && out_stall);

  always_comb begin
    act_full  = sum_r + pcp_pkg::SUM_W'(bias_r);
    pred_now  = !act_full[pcp_pkg::SUM_W-1];
    train_now = op_r && (tgt_r != pred_now);
    // saturate when the upper bits are not all copies of the sign
    if (act_full[pcp_pkg::SUM_W-1:pcp_pkg::ACT_W-1] == '0 ||
        act_full[pcp_pkg::SUM_W-1:pcp_pkg::ACT_W-1] == '1) begin
      act_sat = act_full[pcp_pkg::ACT_W-1:0];
    end else if (act_full[pcp_pkg::SUM_W-1]) begin
      act_sat = {1'b1, {(pcp_pkg::ACT_W-1){1'b0}}};
    end else begin
      act_sat = {1'b0, {(pcp_pkg::ACT_W-1){1'b1}}};
    end
    // error is -1 when the prediction was 1, +1 when it was 0
    step     = pred_now ? -(pcp_pkg::LR_W+2)'(lr_r) : (pcp_pkg::LR_W+2)'(lr_r);
    bias_sum = (pcp_pkg::WGT_W+2)'(bias_r) + (pcp_pkg::WGT_W+2)'(step);
  end

  // ring control
  always_comb begin
    cell_ctrl.shift = store || (state_r == ST_ALIGN) || (state_r == ST_TRAIN);
    cell_ctrl.clr   = eval_go && !train_now;
    case (state_r)
      ST_ALIGN: feed_mode = pcp_pkg::FEED_PASS;
      ST_TRAIN: feed_mode = pcp_pkg::FEED_UPDATE;
      default:  feed_mode = pcp_pkg::FEED_LOAD;
    endcase
  end

  pcp_upd u_upd (
    .mode    (feed_mode),
    .new_f   (in_feature),
    .head_w  (w_q[0]),
    .head_f  (f_q[0]),
    .lr      (lr_r),
    .err_neg (err_neg_r),
    .tail_w  (tail_w),
    .tail_f  (tail_f)
  );

  for (genvar i = 0; i < N_FEATURES; i++) begin : g_cell
    if (i == N_FEATURES - 1) begin : g_tail
      pcp_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cell_ctrl),
        .w_in  (tail_w),
        .f_in  (tail_f),
        .w_q   (w_q[i]),
        .f_q   (f_q[i])
      );
    end else begin : g_mid
      pcp_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cell_ctrl),
        .w_in  (w_q[i+1]),
        .f_in  (f_q[i+1]),
        .w_q   (w_q[i]),
        .f_q   (f_q[i])
      );
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_is_last) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (eval_go) begin
          if (pos_r != N_CNT) begin
            state_nxt = ST_ALIGN;
          end else if (train_now) begin
            state_nxt = ST_TRAIN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ALIGN: begin
        if (cnt_r == PW'(1)) begin
          state_nxt = train_r ? ST_TRAIN : ST_IDLE;
        end
      end
      ST_TRAIN: begin
        if (cnt_r == PW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lr_r        <= pcp_pkg::LR_RESET;
      bias_r      <= '0;
      sum_r       <= '0;
      prod_v_r    <= 1'b0;
      pos_r       <= '0;
      cnt_r       <= '0;
      train_r     <= 1'b0;
      err_neg_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        lr_r <= cfg_data;
      end

      // head weight times feature, registered and folded into the sum in the following cycle
      prod_v_r <= store;
      if (store) begin
        prod_r <= pcp_pkg::PROD_W'(in_feature) * pcp_pkg::PROD_W'(w_q[0]);
        pos_r  <= pos_r + PW'(1);
      end
      if (prod_v_r) begin
        sum_r <= sum_r + pcp_pkg::SUM_W'(prod_r);
      end

      if (in_xfer && in_is_last) begin
        op_r  <= in_opcode;
        tgt_r <= in_target;
      end

      if (eval_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (eval_go) begin
        out_pred_r  <= pred_now;
        out_act_r   <= act_sat;
        train_r     <= train_now;
        err_neg_r   <= pred_now;
        sum_r       <= '0;
        pos_r       <= '0;
        if (train_now) begin
          bias_r <= pcp_pkg::sat_w(bias_sum);
        end
        if (pos_r != N_CNT) begin
          cnt_r <= N_CNT - pos_r;
        end else begin
          cnt_r <= N_CNT;
        end
      end

      if (state_r == ST_ALIGN) begin
        cnt_r <= (cnt_r == PW'(1)) ? N_CNT : cnt_r - PW'(1);
      end
      if (state_r == ST_TRAIN) begin
        cnt_r <= cnt_r - PW'(1);
      end
    end
  end

endmodule

// ===== dv/pcp_tb_pkg.sv =====
`timescale 1ns / 1ps
// opcode names shared by the perceptron testbench files
// no dependencies

package pcp_tb_pkg;

  typedef enum logic {
    OP_PREDICT = 1'b0,
    OP_TRAIN   = 1'b1
  } op_t;

endpackage

// ===== dv/pcp_result_checker.sv =====
`timescale 1ns / 1ps
// checker for the perceptron unit: watches all three channels, keeps its own
// weights, bias and sample state, and compares every result transfer
// depends on pcp_pkg and pcp_tb_pkg

module pcp_result_checker #(
  parameter int unsigned N_FEATURES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [pcp_pkg::FEAT_W-1:0] in_feature,
  input  logic                              in_is_last,
  input  logic                              in_opcode,
  input  logic                              in_target,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              out_prediction,
  input  logic signed [pcp_pkg::ACT_W-1:0]  out_activation,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic        [pcp_pkg::LR_W-1:0]   cfg_data,
  output int                                mismatches,
  output int                                results_owed
);

  localparam longint WGT_MAX = (longint'(1) <<< (pcp_pkg::WGT_W - 1)) - 1;
  localparam longint WGT_MIN = -(longint'(1) <<< (pcp_pkg::WGT_W - 1));
  localparam longint ACT_MAX = (longint'(1) <<< (pcp_pkg::ACT_W - 1)) - 1;
  localparam longint ACT_MIN = -(longint'(1) <<< (pcp_pkg::ACT_W - 1));

  typedef struct {
    logic                              prediction;
    logic signed [pcp_pkg::ACT_W-1:0]  activation;
  } sample_result_t;

  sample_result_t                    owed_results[$];
  logic        [pcp_pkg::LR_W-1:0]   rate;
  logic signed [pcp_pkg::WGT_W-1:0]  weights [N_FEATURES];
  logic signed [pcp_pkg::WGT_W-1:0]  bias;
  logic signed [pcp_pkg::FEAT_W-1:0] held_features [N_FEATURES];
  logic signed [pcp_pkg::SUM_W-1:0]  partial_sum;
  int unsigned                       seen;

  function automatic logic signed [pcp_pkg::WGT_W-1:0] clamp_weight(input longint v);
    if (v > WGT_MAX) return pcp_pkg::WGT_W'(WGT_MAX);
    if (v < WGT_MIN) return pcp_pkg::WGT_W'(WGT_MIN);
    return pcp_pkg::WGT_W'(v);
  endfunction

  function automatic logic signed [pcp_pkg::ACT_W-1:0] clamp_activation(input longint v);
    if (v > ACT_MAX) return pcp_pkg::ACT_W'(ACT_MAX);
    if (v < ACT_MIN) return pcp_pkg::ACT_W'(ACT_MIN);
    return pcp_pkg::ACT_W'(v);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic clear_sample();
    foreach (held_features[j]) held_features[j] = '0;
    partial_sum = '0;
    seen = 0;
  endtask

  task automatic take_feature(input logic signed [pcp_pkg::FEAT_W-1:0] f,
                              input logic last, input logic op, input logic tgt);
    longint         act;
    longint         step;
    logic           pred;
    sample_result_t res;
    // features past the size are dropped
    if (seen < N_FEATURES) begin
      held_features[seen] = f;
      partial_sum = partial_sum +
                    pcp_pkg::SUM_W'(longint'(f) * longint'(weights[seen]));
      seen++;
    end
    if (!last) return;
    act  = longint'(partial_sum) + longint'(bias);
    pred = (act >= 0);
    if (op == pcp_tb_pkg::OP_TRAIN && tgt != pred) begin
      step = tgt ? longint'(rate) : -longint'(rate);
      foreach (weights[j])
        weights[j] = clamp_weight(longint'(weights[j]) + step * longint'(held_features[j]));
      bias = clamp_weight(longint'(bias) + step);
    end
    res.prediction = pred;
    res.activation = clamp_activation(act);
    owed_results.push_back(res);
    clear_sample();
  endtask

  task automatic check_result();
    sample_result_t want;
    if (owed_results.size() == 0) begin
      report_mismatch($sformatf("result transfer with nothing owed (act %0d)", out_activation));
      return;
    end
    want = owed_results.pop_front();
    if (out_prediction !== want.prediction)
      report_mismatch($sformatf("prediction %b, want %b", out_prediction, want.prediction));
    if (out_activation !== want.activation)
      report_mismatch($sformatf("activation %0d, want %0d", out_activation, want.activation));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rate = pcp_pkg::LR_RESET;
      foreach (weights[j]) weights[j] = '0;
      bias = '0;
      clear_sample();
      owed_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) rate = cfg_data;
      if (in_valid && !in_stall) take_feature(in_feature, in_is_last, in_opcode, in_target);
      if (out_valid && !out_stall) check_result();
    end
    results_owed = owed_results.size();
  end

endmodule

// ===== dv/perceptron_online_train_predict_unit_test.sv =====
`timescale 1ns / 1ps
// top of the perceptron unit testbench: clock, reset, feature stream, result
// sink and learning-rate writes; checking sits in pcp_result_checker
// depends on pcp_pkg, pcp_tb_pkg, pcp_result_checker and the unit itself

module perceptron_online_train_predict_unit_test;

  localparam int unsigned N_FEAT = 8;
  // out_valid rises from ST_EVAL after the last feature, then the ring goes home
  // and may take a training lap; this covers both with room to spare
  localparam int SETTLE_CYCLES = 4 * N_FEAT + 8;
  // longest quiet stretch of a good run is a drain plus settle plus a few idle draws
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 240;
  localparam int N_PHASES       = 8;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic signed [pcp_pkg::FEAT_W-1:0] in_feature;
  logic                              in_is_last;
  logic                              in_opcode;
  logic                              in_target;
  logic                              out_valid;
  logic                              out_stall;
  logic                              out_prediction;
  logic signed [pcp_pkg::ACT_W-1:0]  out_activation;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic        [pcp_pkg::LR_W-1:0]   cfg_data;

  int mismatches;
  int results_owed;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit sender_idle_on = 1'b0;
  bit sink_idle_on = 1'b0;

  // extremes of the feature range, both signs of one, and zero in one sample
  byte sweep_features [8] = '{127, -128, 1, -1, 0, 64, -64, 5};
  // rate per phase; the later ones are redrawn at random
  logic [pcp_pkg::LR_W-1:0] phase_rates [N_PHASES] = '{8'd0, 8'd255, 8'd1, 8'd128,
                                                       8'd26, 8'd0, 8'd0, 8'd0};

  always #1 clk = ~clk;

  perceptron_online_train_predict_unit #(
    .N_FEATURES(N_FEAT)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_feature(in_feature),
    .in_is_last(in_is_last),
    .in_opcode(in_opcode),
    .in_target(in_target),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_prediction(out_prediction),
    .out_activation(out_activation),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  pcp_result_checker #(
    .N_FEATURES(N_FEAT)
  ) i_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_feature(in_feature),
    .in_is_last(in_is_last),
    .in_opcode(in_opcode),
    .in_target(in_target),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_prediction(out_prediction),
    .out_activation(out_activation),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .results_owed(results_owed)
  );

  // watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result sink: a fresh hold-off per transfer, then wait for the transfer
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      hold = sink_idle_on ? $urandom_range(0, 6) : 0;
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one feature transfer; returns just after the accepting edge, with valid
  // still high so that a back-to-back item needs no extra drop
  task automatic send_feature(input logic signed [pcp_pkg::FEAT_W-1:0] f, input logic last,
                              input pcp_tb_pkg::op_t op, input logic tgt);
    int unsigned gap;
    gap = sender_idle_on ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_feature <= f;
    in_is_last <= last;
    in_opcode  <= op;
    in_target  <= tgt;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // sender pause: drop valid, wait for every owed result, then let the ring
  // finish its homing and any training lap
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // learning-rate write; only called right after a drain
  task automatic write_rate(input logic [pcp_pkg::LR_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // a random sample: mostly within the size, some full, some overlong;
  // fields of the non-final transfers are noise the unit must ignore
  task automatic send_random_sample();
    int unsigned len;
    int unsigned pick;
    pcp_tb_pkg::op_t op;
    logic        tgt;
    logic signed [pcp_pkg::FEAT_W-1:0] f;
    pick = $urandom_range(0, 19);
    if (pick < 12) len = $urandom_range(1, N_FEAT);
    else if (pick < 16) len = N_FEAT;
    else len = $urandom_range(N_FEAT + 1, N_FEAT + 4);
    // training samples dominate so the weights keep moving
    op  = ($urandom_range(0, 3) == 0) ? pcp_tb_pkg::OP_PREDICT : pcp_tb_pkg::OP_TRAIN;
    tgt = 1'($urandom_range(0, 1));
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0:       f = pcp_pkg::FEAT_W'(-128);
        1:       f = pcp_pkg::FEAT_W'(127);
        2:       f = '0;
        default: f = pcp_pkg::FEAT_W'($urandom_range(0, 255));
      endcase
      if (i == len - 1) send_feature(f, 1'b1, op, tgt);
      else send_feature(f, 1'b0, pcp_tb_pkg::op_t'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int phase_start;
    logic [pcp_pkg::LR_W-1:0] rate;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_feature = '0;
    in_is_last = 1'b0;
    in_opcode  = pcp_tb_pkg::OP_PREDICT;
    in_target  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed part at the reset rate, weights still zero at first
    // zero weights and bias: activation zero, prediction one
    send_feature(8'sd0, 1'b1, pcp_tb_pkg::OP_PREDICT, 1'b1);
    // full sample of extremes, trained against a wrong prediction
    foreach (sweep_features[i])
      send_feature(sweep_features[i], i == 7, pcp_tb_pkg::OP_TRAIN, 1'b0);
    // overlong sample: the last two features must be dropped
    for (int i = 0; i < 10; i++)
      send_feature(pcp_pkg::FEAT_W'(i * 29 - 100), i == 9, pcp_tb_pkg::OP_TRAIN, 1'b1);
    // short sample: the missing positions count as zero
    send_feature(-8'sd128, 1'b0, pcp_tb_pkg::OP_PREDICT, 1'b1);
    send_feature(8'sd127, 1'b1, pcp_tb_pkg::OP_TRAIN, 1'b1);
    // predict only, with a target equal to the prediction and noisy fields before the end
    send_feature(-8'sd7, 1'b0, pcp_tb_pkg::OP_TRAIN, 1'b1);
    send_feature(8'sd100, 1'b0, pcp_tb_pkg::OP_TRAIN, 1'b0);
    send_feature(8'sd33, 1'b1, pcp_tb_pkg::OP_PREDICT, 1'b1);

    // random phases, each under its own rate and idling mix
    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      rate = (p >= 5) ? pcp_pkg::LR_W'($urandom_range(0, 255)) : phase_rates[p];
      write_rate(rate);
      sender_idle_on = p[0];
      sink_idle_on   = p[1];
      phase_start    = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_random_sample();
        // now and then the sender waits for the unit to empty
        if ($urandom_range(0, 24) == 0) drain_results();
      end
    end

    drain_results();
    if (mismatches == 0 && results_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
